[rtl/core/bpc_pkg.sv]
// shared types and constants of the pressure/temperature compensation block
package bpc_pkg;

   localparam int FRAC_BITS_DEFAULT = 24;
   localparam int SPLIT_BITS        = 24;
   localparam int CSR_ADDR_W        = 6;
   localparam int CSR_DATA_W        = 64;
   localparam int CAL_W             = 48;
   localparam int SCALE_W           = 23;

   localparam logic [SCALE_W-1:0] MIN_SCALE = 23'd253952;

   localparam logic [2:0] REG_CAL_A      = 3'd0;
   localparam logic [2:0] REG_CAL_B      = 3'd1;
   localparam logic [2:0] REG_CAL_C      = 3'd2;
   localparam logic [2:0] REG_PRESS_SCALE = 3'd3;
   localparam logic [2:0] REG_TEMP_SCALE = 3'd4;

   localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [23:0] raw_press;
      logic signed [23:0] raw_temp;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] temp_out;
      logic signed [31:0] press_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [11:0]  c0;
      logic signed [11:0]  c1;
      logic signed [19:0]  c00;
      logic signed [19:0]  c10;
      logic signed [15:0]  c01;
      logic signed [15:0]  c11;
      logic signed [15:0]  c20;
      logic signed [15:0]  c21;
      logic signed [15:0]  c30;
      logic [SCALE_W-1:0]  press_div;
      logic [SCALE_W-1:0]  temp_div;
   } cal_coef_type;

endpackage

[rtl/core/bpc_stream_if.sv]
// valid/ready stream channel carrying one payload per beat
interface bpc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/baro_pressure_temp_compensation.sv]
// top level of the barometric pressure and temperature compensation pipeline
//
//   port       dir   beat / access
//   req_chan   in    raw_press, raw_temp (24-bit signed each)
//   rsp_chan   out   temp_out (1/256 C), press_out (1/64 Pa), 32-bit signed
//   csr_*      in    apb, five registers at byte address 8*i, 64-bit data
//
// one sample pair enters per cycle while the output is not stalled; the pipeline
// is the FRAC_BITS+7 divider stages followed by twelve polynomial stages
// reset clears the stage valid bits and loads the register reset values
// a stalled output holds its beat; earlier stages keep filling empty slots
module baro_pressure_temp_compensation #(
   parameter int FRAC_BITS = bpc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   bpc_stream_if.sink                        req_chan,
   bpc_stream_if.source                      rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bpc_pkg::*;

   cal_coef_type         coef;
   logic                 div_valid;
   logic                 div_ready;
   logic [FRAC_BITS+5:0] press_mag;
   logic [FRAC_BITS+5:0] temp_mag;
   logic                 press_neg;
   logic                 temp_neg;
   logic signed [31:0]   temp_res;
   logic signed [31:0]   press_res;

   bpc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   bpc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .in_press      (req_chan.payload.raw_press),
      .in_temp       (req_chan.payload.raw_temp),
      .press_div     (coef.press_div),
      .temp_div      (coef.temp_div),
      .out_valid     (div_valid),
      .out_ready     (div_ready),
      .out_press_mag (press_mag),
      .out_temp_mag  (temp_mag),
      .out_press_neg (press_neg),
      .out_temp_neg  (temp_neg)
   );

   bpc_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (div_valid),
      .in_ready     (div_ready),
      .in_press_mag (press_mag),
      .in_temp_mag  (temp_mag),
      .in_press_neg (press_neg),
      .in_temp_neg  (temp_neg),
      .coef         (coef),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_temp     (temp_res),
      .out_press    (press_res)
   );

   assign rsp_chan.payload.temp_out  = temp_res;
   assign rsp_chan.payload.press_out = press_res;

endmodule

[rtl/core/bpc_regs.sv]
// apb register file and calibration coefficient unpacking
module bpc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bpc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output bpc_pkg::cal_coef_type             coef
);
   import bpc_pkg::*;

   logic [CAL_W-1:0]   cal_a_ff;
   logic [CAL_W-1:0]   cal_b_ff;
   logic [CAL_W-1:0]   cal_c_ff;
   logic [SCALE_W-1:0] press_scale_ff;
   logic [SCALE_W-1:0] temp_scale_ff;
   logic [2:0]         reg_idx;
   logic               wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff       <= '0;
         cal_b_ff       <= '0;
         cal_c_ff       <= '0;
         press_scale_ff <= MIN_SCALE;
         temp_scale_ff  <= MIN_SCALE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_CAL_A: begin
               cal_a_ff <= csr_pwdata[CAL_W-1:0];
            end
            REG_CAL_B: begin
               cal_b_ff <= csr_pwdata[CAL_W-1:0];
            end
            REG_CAL_C: begin
               cal_c_ff <= csr_pwdata[CAL_W-1:0];
            end
            REG_PRESS_SCALE: begin
               press_scale_ff <= csr_pwdata[SCALE_W-1:0];
            end
            REG_TEMP_SCALE: begin
               temp_scale_ff <= csr_pwdata[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CAL_A:       csr_prdata = CSR_DATA_W'(cal_a_ff);
         REG_CAL_B:       csr_prdata = CSR_DATA_W'(cal_b_ff);
         REG_CAL_C:       csr_prdata = CSR_DATA_W'(cal_c_ff);
         REG_PRESS_SCALE: csr_prdata = CSR_DATA_W'(press_scale_ff);
         REG_TEMP_SCALE:  csr_prdata = CSR_DATA_W'(temp_scale_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // byte 0 sits in the top byte of each word
   always_comb begin
      coef.c0  = cal_a_ff[47:36];
      coef.c1  = cal_a_ff[35:24];
      coef.c00 = cal_a_ff[23:4];
      coef.c10 = {cal_a_ff[3:0], cal_b_ff[47:32]};
      coef.c01 = cal_b_ff[31:16];
      coef.c11 = cal_b_ff[15:0];
      coef.c20 = cal_c_ff[47:32];
      coef.c21 = cal_c_ff[31:16];
      coef.c30 = cal_c_ff[15:0];
      coef.press_div = (press_scale_ff < MIN_SCALE) ? MIN_SCALE : press_scale_ff;
      coef.temp_div  = (temp_scale_ff < MIN_SCALE) ? MIN_SCALE : temp_scale_ff;
   end

endmodule

[rtl/core/bpc_div.sv]
// pipelined restoring divider, one quotient bit per stage after the input stage, pressure and temperature lanes
module bpc_div #(
   parameter int FRAC_BITS = bpc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [23:0]                 in_press,
   input  logic signed [23:0]                 in_temp,
   input  logic [bpc_pkg::SCALE_W-1:0]        press_div,
   input  logic [bpc_pkg::SCALE_W-1:0]        temp_div,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [FRAC_BITS+5:0]               out_press_mag,
   output logic [FRAC_BITS+5:0]               out_temp_mag,
   output logic                               out_press_neg,
   output logic                               out_temp_neg
);
   import bpc_pkg::*;

   localparam int QW = FRAC_BITS + 6;
   localparam int NS = QW + 1;

   logic               v_ff   [NS];
   logic               adv    [NS+1];
   logic [SCALE_W-1:0] rem_ff [NS][2];
   logic [SCALE_W-1:0] rem_in [NS][2];
   logic [QW-1:0]      qd_ff  [NS][2];
   logic [QW-1:0]      qd_in  [NS][2];
   logic               neg_ff [NS][2];
   logic               neg_in [NS][2];
   logic [23:0]        raw_lane [2];
   logic [SCALE_W-1:0] div_lane [2];

   assign raw_lane[0] = in_press;
   assign raw_lane[1] = in_temp;
   assign div_lane[0] = press_div;
   assign div_lane[1] = temp_div;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      logic [23:0] mag;
      logic [23:0] trial;
      logic        ge;
      for (int l = 0; l < 2; l++) begin
         mag = raw_lane[l][23] ? (~raw_lane[l] + 24'd1) : raw_lane[l];
         // top bits of the shifted dividend always stay below the divisor
         rem_in[0][l] = SCALE_W'(mag >> 6);
         qd_in[0][l]  = {mag[5:0], {FRAC_BITS{1'b0}}};
         neg_in[0][l] = raw_lane[l][23];
         for (int k = 1; k < NS; k++) begin
            trial        = {rem_ff[k-1][l], qd_ff[k-1][l][QW-1]};
            ge           = (trial >= {1'b0, div_lane[l]});
            rem_in[k][l] = ge ? SCALE_W'(trial - {1'b0, div_lane[l]}) : trial[SCALE_W-1:0];
            qd_in[k][l]  = {qd_ff[k-1][l][QW-2:0], ge};
            neg_in[k][l] = neg_ff[k-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               qd_ff[k][l]  <= qd_in[k][l];
               neg_ff[k][l] <= neg_in[k][l];
            end
         end
      end
   end

   assign in_ready      = adv[0];
   assign out_valid     = v_ff[NS-1];
   assign out_press_mag = qd_ff[NS-1][0];
   assign out_temp_mag  = qd_ff[NS-1][1];
   assign out_press_neg = neg_ff[NS-1][0];
   assign out_temp_neg  = neg_ff[NS-1][1];

endmodule

[rtl/core/bpc_poly.sv]
// pipelined compensation polynomial with split wide products and an output stage that saturates pressure
module bpc_poly #(
   parameter int FRAC_BITS = bpc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [FRAC_BITS+5:0]  in_press_mag,
   input  logic [FRAC_BITS+5:0]  in_temp_mag,
   input  logic                  in_press_neg,
   input  logic                  in_temp_neg,
   input  bpc_pkg::cal_coef_type coef,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [31:0]    out_temp,
   output logic signed [31:0]    out_press
);
   import bpc_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int LO  = SPLIT_BITS;
   localparam int PW  = F + 7;
   localparam int W1  = F + 22;
   localparam int W2  = F + 27;
   localparam int WP  = F + 33;
   localparam int WT  = F + 19;
   localparam int NS  = 12;
   localparam int PVW = WP - F + 6;
   localparam int TVW = WT - F + 8;

   logic adv  [NS+1];
   logic v_ff [NS];

   logic signed [PW-1:0]         psc_ff [0:5];
   logic signed [PW-1:0]         tsc_ff [0:5];
   logic signed [WT-1:0]         tq_ff  [2:9];
   logic signed [PW+15:0]        ma_ff, mg_ff;
   logic signed [PW+11:0]        mt_ff;
   logic signed [W1-1:0]         h1_ff, g1_ff;
   logic signed [PW+LO:0]        hl_ff, gl_ff;
   logic signed [PW+W1-LO-1:0]   hh_ff, gh_ff;
   logic                         hneg_ff, gneg_ff;
   logic signed [PW+W1-1:0]      hp_ff, gp_ff;
   logic signed [W2-1:0]         h2_ff, g2_ff;
   logic signed [PW+LO:0]        h2l_ff, g2l_ff;
   logic signed [PW+W2-LO-1:0]   h2h_ff, g2h_ff;
   logic                         hneg2_ff, gneg2_ff;
   logic signed [PW+W2-1:0]      hp2_ff, gp2_ff;
   logic signed [WP-1:0]         h3_ff, gt_ff, pq_ff, pqb_ff;
   logic signed [WT-1:0]         tqb_ff;
   logic signed [31:0]           temp_ff, press_ff;

   logic signed [PW+W1-1:0]      hbias, gbias;
   logic signed [PW+W2-1:0]      hbias2, gbias2;
   logic signed [WP-1:0]         pbias;
   logic signed [WT-1:0]         tbias;
   logic signed [PW+W1-F-1:0]    hq, gq;
   logic signed [PW+W2-F-1:0]    hq2, gq2;
   logic signed [PVW-1:0]        pv;
   logic signed [TVW-1:0]        tv;

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // rounding toward zero: add 2^n-1 before the arithmetic shift when negative
   always_comb begin
      hbias  = '0;
      gbias  = '0;
      hbias2 = '0;
      gbias2 = '0;
      pbias  = '0;
      tbias  = '0;
      if (hneg_ff) hbias[F-1:0] = '1;
      if (gneg_ff) gbias[F-1:0] = '1;
      if (hneg2_ff) hbias2[F-1:0] = '1;
      if (gneg2_ff) gbias2[F-1:0] = '1;
      if (pq_ff[WP-1]) pbias[F-7:0] = '1;
      if (tq_ff[9][WT-1]) tbias[F-9:0] = '1;
   end

   assign hq  = hp_ff[PW+W1-1:F];
   assign gq  = gp_ff[PW+W1-1:F];
   assign hq2 = hp2_ff[PW+W2-1:F];
   assign gq2 = gp2_ff[PW+W2-1:F];
   assign pv  = pqb_ff[WP-1:F-6];
   assign tv  = tqb_ff[WT-1:F-8];

   always_ff @(posedge clock) begin
      // signed scaled values
      if (adv[0]) begin
         psc_ff[0] <= in_press_neg ? -$signed({1'b0, in_press_mag})
                                   : $signed({1'b0, in_press_mag});
         tsc_ff[0] <= in_temp_neg ? -$signed({1'b0, in_temp_mag})
                                  : $signed({1'b0, in_temp_mag});
      end
      for (int k = 1; k < 6; k++) begin
         if (adv[k]) begin
            psc_ff[k] <= psc_ff[k-1];
            tsc_ff[k] <= tsc_ff[k-1];
         end
      end
      for (int k = 3; k < 10; k++) begin
         if (adv[k]) begin
            tq_ff[k] <= tq_ff[k-1];
         end
      end
      // coefficient products
      if (adv[1]) begin
         ma_ff <= psc_ff[0] * coef.c30;
         mg_ff <= psc_ff[0] * coef.c21;
         mt_ff <= coef.c1 * tsc_ff[0];
      end
      if (adv[2]) begin
         h1_ff    <= (W1'(coef.c20) <<< F) + W1'(ma_ff);
         g1_ff    <= (W1'(coef.c11) <<< F) + W1'(mg_ff);
         tq_ff[2] <= (WT'(coef.c0) <<< (F - 1)) + WT'(mt_ff);
      end
      // psc*h1 and psc*g1 as low and high partial products
      if (adv[3]) begin
         hl_ff   <= psc_ff[2] * $signed({1'b0, h1_ff[LO-1:0]});
         hh_ff   <= psc_ff[2] * $signed(h1_ff[W1-1:LO]);
         gl_ff   <= psc_ff[2] * $signed({1'b0, g1_ff[LO-1:0]});
         gh_ff   <= psc_ff[2] * $signed(g1_ff[W1-1:LO]);
         hneg_ff <= psc_ff[2][PW-1] ^ h1_ff[W1-1];
         gneg_ff <= psc_ff[2][PW-1] ^ g1_ff[W1-1];
      end
      if (adv[4]) begin
         hp_ff <= ((PW+W1)'(hh_ff) <<< LO) + (PW+W1)'(hl_ff) + hbias;
         gp_ff <= ((PW+W1)'(gh_ff) <<< LO) + (PW+W1)'(gl_ff) + gbias;
      end
      if (adv[5]) begin
         h2_ff <= (W2'(coef.c10) <<< F) + W2'(hq);
         g2_ff <= (W2'(coef.c01) <<< F) + W2'(gq);
      end
      // psc*h2 and tsc*g2
      if (adv[6]) begin
         h2l_ff   <= psc_ff[5] * $signed({1'b0, h2_ff[LO-1:0]});
         h2h_ff   <= psc_ff[5] * $signed(h2_ff[W2-1:LO]);
         g2l_ff   <= tsc_ff[5] * $signed({1'b0, g2_ff[LO-1:0]});
         g2h_ff   <= tsc_ff[5] * $signed(g2_ff[W2-1:LO]);
         hneg2_ff <= psc_ff[5][PW-1] ^ h2_ff[W2-1];
         gneg2_ff <= tsc_ff[5][PW-1] ^ g2_ff[W2-1];
      end
      if (adv[7]) begin
         hp2_ff <= ((PW+W2)'(h2h_ff) <<< LO) + (PW+W2)'(h2l_ff) + hbias2;
         gp2_ff <= ((PW+W2)'(g2h_ff) <<< LO) + (PW+W2)'(g2l_ff) + gbias2;
      end
      if (adv[8]) begin
         h3_ff <= (WP'(coef.c00) <<< F) + WP'(hq2);
         gt_ff <= WP'(gq2);
      end
      if (adv[9]) begin
         pq_ff <= h3_ff + gt_ff;
      end
      if (adv[10]) begin
         pqb_ff <= pq_ff + pbias;
         tqb_ff <= tq_ff[9] + tbias;
      end
      // output register, pressure saturates to 32 bits
      if (adv[11]) begin
         temp_ff <= 32'(tv);
         if ((&pv[PVW-1:31]) || !(|pv[PVW-1:31])) begin
            press_ff <= pv[31:0];
         end else begin
            press_ff <= pv[PVW-1] ? OUT_MIN : OUT_MAX;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_temp  = temp_ff;
   assign out_press = press_ff;

endmodule

[tb/tb.sv]
// testbench for the barometric pressure and temperature compensation block
`timescale 1ns / 1ps

module tb;
   import bpc_pkg::*;

   typedef struct {
      int                 stage;
      logic signed [23:0] press;
      logic signed [23:0] temp;
      bit                 known;
      logic signed [31:0] t_exp;
      logic signed [31:0] p_exp;
   } pair_row_type;

   typedef struct {
      logic signed [23:0] press;
      logic signed [23:0] temp;
      bit                 known;
      rsp_payload_type    exp;
   } sent_pair_type;

   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [23:0] RAW_MAX = 24'sh7F_FFFF;
   localparam logic signed [23:0] RAW_MIN = 24'sh80_0000;
   localparam int PIPE_WAIT = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bpc_stream_if #(.payload_type(req_payload_type)) req_chan ();
   bpc_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   baro_pressure_temp_compensation uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // shadow copy of the calibration registers
   logic [CAL_W-1:0]   cal_a = '0, cal_b = '0, cal_c = '0;
   logic [SCALE_W-1:0] press_div = MIN_SCALE, temp_div = MIN_SCALE;

   sent_pair_type   sent_q[$];
   rsp_payload_type expected_q[$];
   int errors = 0;
   int n_pairs = 0;
   int n_results = 0;
   int n_settings = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   function automatic longint sat_add(longint a, longint b);
      logic signed [64:0] sa, sb, s;
      sa = a;
      sb = b;
      s = sa + sb;
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   // exact product, magnitude shifted down by the fraction width, saturated
   function automatic longint qmul(longint a, longint b);
      logic signed [127:0] pa, pb, p;
      logic [127:0] m;
      pa = a;
      pb = b;
      p = pa * pb;
      m = (p < 0) ? -p : p;
      m = m >> FRAC_BITS_DEFAULT;
      if (p < 0) begin
         if (m > 128'h8000_0000_0000_0000) return S64_MIN;
         return -$signed(m[63:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF_FFFF) return S64_MAX;
      return $signed(m[63:0]);
   endfunction

   function automatic logic signed [31:0] to_out32(longint v, int sh);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      m = m >> sh;
      if (v < 0) begin
         if (m > 64'h8000_0000) return OUT_MIN;
         return -$signed(m[31:0]);
      end
      if (m > 64'h7FFF_FFFF) return OUT_MAX;
      return $signed(m[31:0]);
   endfunction

   function automatic longint scale_raw(logic signed [23:0] raw, logic [SCALE_W-1:0] sc);
      longint d, r;
      d = (sc < MIN_SCALE) ? MIN_SCALE : sc;
      r = raw;
      return (r * (64'sd1 <<< FRAC_BITS_DEFAULT)) / d;
   endfunction

   function automatic rsp_payload_type compensate(logic signed [23:0] rp,
                                                  logic signed [23:0] rt);
      logic [143:0] cal;
      longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
      longint one, psc, tsc, tq, h, g, pq;
      rsp_payload_type r;
      cal = {cal_a, cal_b, cal_c};
      c0  = $signed(cal[143:132]);
      c1  = $signed(cal[131:120]);
      c00 = $signed(cal[119:100]);
      c10 = $signed(cal[99:80]);
      c01 = $signed(cal[79:64]);
      c11 = $signed(cal[63:48]);
      c20 = $signed(cal[47:32]);
      c21 = $signed(cal[31:16]);
      c30 = $signed(cal[15:0]);
      one = 64'sd1 <<< FRAC_BITS_DEFAULT;
      psc = scale_raw(rp, press_div);
      tsc = scale_raw(rt, temp_div);
      tq = sat_add(c0 * (one / 2), c1 * tsc);
      h = sat_add(c20 * one, psc * c30);
      h = sat_add(c10 * one, qmul(psc, h));
      h = sat_add(c00 * one, qmul(psc, h));
      g = sat_add(c11 * one, psc * c21);
      g = sat_add(c01 * one, qmul(psc, g));
      pq = sat_add(h, qmul(tsc, g));
      r.temp_out  = to_out32(tq, FRAC_BITS_DEFAULT - 8);
      r.press_out = to_out32(pq, FRAC_BITS_DEFAULT - 6);
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what,
               $signed(got), $signed(want), $realtime);
   endtask

   // expectation is formed when the request beat is taken
   always @(posedge clock) begin : scoreboard
      sent_pair_type   s;
      rsp_payload_type e, got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            s = sent_q.pop_front();
            expected_q.push_back(s.known ? s.exp : compensate(s.press, s.temp));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            n_results++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("unexpected result beat at %0t", $realtime);
            end else begin
               e = expected_q.pop_front();
               if (got.temp_out !== e.temp_out) report("temp_out", got.temp_out, e.temp_out);
               if (got.press_out !== e.press_out)
                  report("press_out", got.press_out, e.press_out);
            end
         end
      end
   end

   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 3;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CAL_A:       cal_a = data[CAL_W-1:0];
         REG_CAL_B:       cal_b = data[CAL_W-1:0];
         REG_CAL_C:       cal_c = data[CAL_W-1:0];
         REG_PRESS_SCALE: press_div = data[SCALE_W-1:0];
         REG_TEMP_SCALE:  temp_div = data[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                           logic [63:0] ps, logic [63:0] ts);
      csr_write(REG_CAL_A, a);
      csr_write(REG_CAL_B, b);
      csr_write(REG_CAL_C, c);
      csr_write(REG_PRESS_SCALE, ps);
      csr_write(REG_TEMP_SCALE, ts);
      n_settings++;
   endtask

   task automatic send_pair(logic signed [23:0] p, logic signed [23:0] t, bit known,
                            logic signed [31:0] te, logic signed [31:0] pe);
      sent_pair_type s;
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      s.press = p;
      s.temp = t;
      s.known = known;
      s.exp.temp_out = te;
      s.exp.press_out = pe;
      sent_q.push_back(s);
      req_chan.valid <= 1'b1;
      req_chan.payload <= '{raw_press: p, raw_temp: t};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      n_pairs++;
   endtask

   // stop sending and let the pipeline empty out
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sent_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_raw();
      case ($urandom_range(9))
         0: return RAW_MAX;
         1: return RAW_MIN;
         2: return 24'sd0;
         3: return $signed(24'($urandom_range(255))) - 24'sd128;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_scale();
      case ($urandom_range(4))
         0: return MIN_SCALE;
         1: return 64'd7864320;
         2: return $urandom_range(253951);
         default: return $urandom_range(7864320, 253952);
      endcase
   endfunction

   // stage 0 after reset, 1 all calibration bits set, 2 large mixed coefficients
   pair_row_type directed[] = '{
      '{0, 24'sd0,  24'sd0,  1, 32'sd0, 32'sd0},
      '{0, RAW_MAX, RAW_MIN, 1, 32'sd0, 32'sd0},
      '{0, RAW_MIN, RAW_MAX, 1, 32'sd0, 32'sd0},
      '{1, 24'sd0,  24'sd0,  1, -32'sd128, -32'sd64},
      '{1, RAW_MAX, RAW_MAX, 0, 32'sd0, 32'sd0},
      '{1, RAW_MIN, RAW_MIN, 0, 32'sd0, 32'sd0},
      '{1, RAW_MAX, RAW_MIN, 0, 32'sd0, 32'sd0},
      '{1, 24'sd1,  -24'sd1, 0, 32'sd0, 32'sd0},
      '{2, 24'sd0,  24'sd0,  0, 32'sd0, 32'sd0},
      '{2, RAW_MAX, RAW_MAX, 0, 32'sd0, 32'sd0},
      '{2, RAW_MIN, RAW_MIN, 0, 32'sd0, 32'sd0},
      '{2, RAW_MIN, RAW_MAX, 0, 32'sd0, 32'sd0},
      '{2, RAW_MAX, RAW_MIN, 0, 32'sd0, 32'sd0},
      '{2, -24'sd1, 24'sd1,  0, 32'sd0, 32'sd0},
      '{2, 24'sd4096, -24'sd4096, 0, 32'sd0, 32'sd0}
   };

   initial begin : stimulus
      int stage;
      int idle_set[4];
      int stall_set[4];
      idle_set = '{0, 80, 0, 25};
      stall_set = '{0, 0, 80, 25};
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (PIPE_WAIT) @(posedge clock);
      stage = 0;
      foreach (directed[i]) begin
         if (directed[i].stage != stage) begin
            drain();
            stage = directed[i].stage;
            if (stage == 1) begin
               // scale below range and bits above the register width
               load_cal('1, '1, '1, 64'd0, 64'hFFFF_FFFF_FF80_0000);
            end else begin
               load_cal(48'h7FF_800_7FFFF_8, 64'hFFFF_0000_7FFF_8000, 48'h7FFF_8000_7FFF,
                        '1, 64'd7864320);
               // writes past the last register leave everything alone
               csr_write(3'd5, '1);
               csr_write(3'd6, '1);
               csr_write(3'd7, '1);
            end
         end
         send_pair(directed[i].press, directed[i].temp, directed[i].known,
                   directed[i].t_exp, directed[i].p_exp);
      end
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_set[ph];
         stall_pct = stall_set[ph];
         load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  pick_scale(), pick_scale());
         for (int k = 0; k < 100; k++) begin
            if (k == 50) begin
               load_cal_mid: begin
                  drain();
                  if (ph != 0)
                     load_cal({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, pick_scale(), pick_scale());
               end
            end
            send_pair(pick_raw(), pick_raw(), 0, 32'sd0, 32'sd0);
         end
         drain();
      end
      idle_pct = 0;
      stall_pct = 0;

      $display("%0d sample pairs over %0d calibration settings, %0d results checked",
               n_pairs, n_settings, n_results);
      $display("covered raw extremes, saturation, scale clamping and idle/stall mixes");
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
